### rtl/rpn_pkg.sv
package rpn_pkg;

  localparam int unsigned STACK_DEPTH = 256;
  localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned ERR_W       = 2;

  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_MUL   = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_DIV   = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [DATA_W-1:0] RADIX    = 32'd10;

  localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
  localparam logic [ERR_W-1:0] ERR_UNDERFLOW = 2'd1;
  localparam logic [ERR_W-1:0] ERR_OVERFLOW  = 2'd2;
  localparam logic [ERR_W-1:0] ERR_DIV_ZERO  = 2'd3;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] num;
    logic [DATA_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quot;
  } div_rsp_t;

endpackage

### rtl/rpn_if.sv
interface rpn_char_if;
  import rpn_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);
endinterface

interface rpn_result_if;
  import rpn_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] result_value;
  logic [ERR_W-1:0]         error_code;

  modport source (output valid, output result_value, output error_code, input ready);
  modport sink   (input valid, input result_value, input error_code, output ready);
endinterface

### rtl/rpn_div.sv
module rpn_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rpn_pkg::div_req_t req_i,
  output rpn_pkg::div_rsp_t rsp_o
);
  import rpn_pkg::*;

  localparam int unsigned STEP_W = $clog2(DATA_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [DATA_W-1:0] rem_q, rem_d;
  logic [DATA_W-1:0] quo_q, quo_d;
  logic [DATA_W-1:0] dm_q, dm_d;
  logic              neg_q, neg_d;
  logic [DATA_W:0]   rem_sh;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dm_d   = dm_q;
    neg_d  = neg_q;
    rem_sh = {rem_q, quo_q[DATA_W-1]};
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = STEP_W'(DATA_W - 1);
      rem_d  = '0;
      quo_d  = req_i.num[DATA_W-1] ? (DATA_W'(0) - req_i.num) : req_i.num;
      dm_d   = req_i.den[DATA_W-1] ? (DATA_W'(0) - req_i.den) : req_i.den;
      neg_d  = req_i.num[DATA_W-1] ^ req_i.den[DATA_W-1];
    end else if (busy_q) begin
      // restoring step, one quotient bit per cycle
      if (rem_sh >= {1'b0, dm_q}) begin
        rem_d = DATA_W'(rem_sh - {1'b0, dm_q});
        quo_d = {quo_q[DATA_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[DATA_W-1:0];
        quo_d = {quo_q[DATA_W-2:0], 1'b0};
      end
      step_d = step_q - STEP_W'(1);
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dm_q  <= dm_d;
    neg_q <= neg_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = neg_q ? (DATA_W'(0) - quo_q) : quo_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divider started while busy");
  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while still busy");
  a_done_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && step_q == '0 && !req_i.start) |=> done_q)
    else $error("divider missed its done pulse");

endmodule

### rtl/rpn_expression_evaluator.sv
// channel  | dir | beat payload               | notes
// char_i   | in  | char_in[7:0]               | one ascii character per beat
// res_o    | out | result_value[31:0], error  | one beat per '.' or newline ending
//
// digits, spaces and skipped characters are taken in the idle state
// an operator passes through accept, two stack reads, then execute and write back
// a division also waits for the bit-serial divider
// an expression end passes through accept, one stack read and emit; it waits in emit while the result register is full
// reset clears the stack pointer, number, flags and the result valid flag; the stack
// ram itself is not cleared
module rpn_expression_evaluator (
  input logic         clk_i,
  input logic         rst_ni,
  rpn_char_if.sink    char_i,
  rpn_result_if.source res_o
);
  import rpn_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_POP1 = 6'b000010,
    S_POP2 = 6'b000100,
    S_EXEC = 6'b001000,
    S_DIVW = 6'b010000,
    S_EMIT = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [DATA_W-1:0] acc_q, acc_d;
  logic              in_num_q, in_num_d;
  logic              skip_q, skip_d;
  logic [ERR_W-1:0]  err_q, err_d;
  logic [CHAR_W-1:0] c_q, c_d;
  logic [DATA_W-1:0] top_q, top_d;
  logic              hit_q, hit_d;
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_val_q, out_val_d;
  logic [ERR_W-1:0]  out_err_q, out_err_d;

  logic [DATA_W-1:0] mem [STACK_DEPTH];
  logic [DATA_W-1:0] rd_q;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [DATA_W-1:0] mem_wdata;

  div_req_t          div_req;
  div_rsp_t          div_rsp;

  logic              accept;
  logic              is_digit;
  logic              emit_go;
  logic              push_req;
  logic [DATA_W-1:0] push_val;
  logic [DATA_W-1:0] pop_val;
  logic              full;

  assign accept   = char_i.valid && char_i.ready;
  assign is_digit = char_i.char_in inside {[CH_0:CH_9]};
  assign emit_go  = !out_valid_q || res_o.ready;
  assign full     = count_q >= CNT_W'(STACK_DEPTH);
  assign pop_val  = hit_q ? rd_q : '0;

  assign char_i.ready = (state_q == S_IDLE);

  rpn_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    acc_d       = acc_q;
    in_num_d    = in_num_q;
    skip_d      = skip_q;
    err_d       = err_q;
    c_d         = c_q;
    top_d       = top_q;
    hit_d       = hit_q;
    out_valid_d = out_valid_q && !res_o.ready;
    out_val_d   = out_val_q;
    out_err_d   = out_err_q;
    mem_re      = 1'b0;
    mem_raddr   = ADDR_W'(count_q - CNT_W'(1));
    push_req    = 1'b0;
    push_val    = acc_q;
    div_req     = '{start: 1'b0, num: pop_val, den: top_q};

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          c_d = char_i.char_in;
          if (skip_q) begin
            if (char_i.char_in == CH_LF) skip_d = 1'b0;
          end else if (is_digit) begin
            acc_d = (acc_q << 3) + (acc_q << 1)
                  + {{(DATA_W-CHAR_W){1'b0}}, char_i.char_in - CH_0};
            in_num_d = 1'b1;
          end else begin
            if (in_num_q) begin
              push_req = 1'b1;
              push_val = acc_q;
              acc_d    = '0;
              in_num_d = 1'b0;
            end
            if (char_i.char_in != CH_SPACE) state_d = S_POP1;
          end
        end
      end
      S_POP1, S_POP2: begin
        if (state_q == S_POP2) top_d = pop_val;
        hit_d = (count_q != '0);
        if (count_q != '0) begin
          mem_re  = 1'b1;
          count_d = count_q - CNT_W'(1);
        end else if (err_d == ERR_NONE) begin
          err_d = ERR_UNDERFLOW;
        end
        if (state_q == S_POP2) state_d = S_EXEC;
        else if (c_q == CH_DOT || c_q == CH_LF) state_d = S_EMIT;
        else state_d = S_POP2;
      end
      S_EXEC: begin
        state_d = S_IDLE;
        case (c_q)
          CH_PLUS: begin
            push_req = 1'b1;
            push_val = pop_val + top_q;
          end
          CH_MINUS: begin
            push_req = 1'b1;
            push_val = pop_val - top_q;
          end
          CH_MUL: begin
            push_req = 1'b1;
            push_val = DATA_W'(pop_val * top_q);
          end
          CH_DIV: begin
            if (top_q == '0) begin
              if (err_d == ERR_NONE) err_d = ERR_DIV_ZERO;
              push_req = 1'b1;
              push_val = '0;
            end else begin
              div_req.start = 1'b1;
              state_d       = S_DIVW;
            end
          end
          default: ; // any other character only drops two values
        endcase
      end
      S_DIVW: begin
        if (div_rsp.done) begin
          push_req = 1'b1;
          push_val = div_rsp.quot;
          state_d  = S_IDLE;
        end
      end
      S_EMIT: begin
        if (emit_go) begin
          out_valid_d = 1'b1;
          out_val_d   = pop_val;
          out_err_d   = err_q;
          count_d     = '0;
          err_d       = ERR_NONE;
          skip_d      = (c_q == CH_DOT);
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // single write port, shared by number push and operator result
    mem_we    = push_req && !full;
    mem_waddr = count_q[ADDR_W-1:0];
    mem_wdata = push_val;
    if (push_req) begin
      if (full) begin
        if (err_d == ERR_NONE) err_d = ERR_OVERFLOW;
      end else begin
        count_d = count_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      acc_q       <= '0;
      in_num_q    <= 1'b0;
      skip_q      <= 1'b0;
      err_q       <= ERR_NONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      acc_q       <= acc_d;
      in_num_q    <= in_num_d;
      skip_q      <= skip_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q       <= c_d;
    top_q     <= top_d;
    hit_q     <= hit_d;
    out_val_q <= out_val_d;
    out_err_q <= out_err_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_q <= mem[mem_raddr];
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.result_value = out_val_q;
  assign res_o.error_code   = out_err_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(STACK_DEPTH))
    else $error("stack pointer beyond depth");
  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> !full)
    else $error("stack write while full");
  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && emit_go) |=> (count_q == '0 && out_valid_q))
    else $error("expression end did not clear the stack");
  a_div_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> (state_q == S_EXEC && top_q != '0))
    else $error("divider started outside execute");
  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == S_DIVW)
    else $error("divider result with no division pending");

endmodule

### tb/sv/rpn_expression_evaluator_tb.sv
`timescale 1ns / 100ps

import rpn_pkg::*;

typedef logic [CHAR_W-1:0] char_q_t[$];

typedef struct {
  logic signed [DATA_W-1:0] value;
  logic [ERR_W-1:0]         code;
} expr_result_t;

class expr_scoreboard;
  logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
  int unsigned       depth_cnt;
  logic [DATA_W-1:0] num_acc;
  bit                num_open;
  bit                skipping;
  logic [ERR_W-1:0]  first_err;
  expr_result_t      pending_results[$];
  int unsigned       errors;

  function new();
    depth_cnt = 0;
    num_acc   = '0;
    num_open  = 1'b0;
    skipping  = 1'b0;
    first_err = ERR_NONE;
    errors    = 0;
  endfunction

  function void flag(input logic [ERR_W-1:0] code);
    if (first_err == ERR_NONE) first_err = code;
  endfunction

  function void push(input logic [DATA_W-1:0] v);
    if (depth_cnt >= STACK_DEPTH) begin
      flag(ERR_OVERFLOW);
      return;
    end
    stack_mem[depth_cnt] = v;
    depth_cnt++;
  endfunction

  function logic [DATA_W-1:0] pop();
    if (depth_cnt == 0) begin
      flag(ERR_UNDERFLOW);
      return '0;
    end
    depth_cnt--;
    return stack_mem[depth_cnt];
  endfunction

  function int unsigned outstanding();
    return pending_results.size();
  endfunction

  // returns 0 when the character is swallowed by the skip after a '.'
  function bit note_char(input logic [CHAR_W-1:0] c);
    logic [DATA_W-1:0] top;
    logic [DATA_W-1:0] below;
    logic [DATA_W-1:0] quot;
    expr_result_t      res;
    if (skipping) begin
      if (c == CH_LF) skipping = 1'b0;
      return 1'b0;
    end
    if (c >= CH_0 && c <= CH_9) begin
      num_acc  = num_acc * RADIX + DATA_W'(c - CH_0);
      num_open = 1'b1;
      return 1'b1;
    end
    if (num_open) begin
      push(num_acc);
      num_acc  = '0;
      num_open = 1'b0;
    end
    if (c == CH_SPACE) return 1'b1;
    if (c == CH_DOT || c == CH_LF) begin
      res.value = pop();
      res.code  = first_err;
      pending_results.push_back(res);
      depth_cnt = 0;
      first_err = ERR_NONE;
      if (c == CH_DOT) skipping = 1'b1;
      return 1'b1;
    end
    top   = pop();
    below = pop();
    case (c)
      CH_PLUS:  push(below + top);
      CH_MINUS: push(below - top);
      CH_MUL:   push(below * top);
      CH_DIV: begin
        if (top == '0) begin
          flag(ERR_DIV_ZERO);
          push('0);
        end else begin
          // most negative over -1 wraps back to itself
          if (below == {1'b1, {(DATA_W-1){1'b0}}} && top == '1) quot = below;
          else quot = $signed(below) / $signed(top);
          push(quot);
        end
      end
      default: ;
    endcase
    return 1'b1;
  endfunction

  task report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  task check_result(input logic signed [DATA_W-1:0] got_val, input logic [ERR_W-1:0] got_code);
    expr_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("result %0d code %0d with no expression ended",
                                got_val, got_code));
      return;
    end
    want = pending_results.pop_front();
    if (got_val !== want.value)
      report_mismatch($sformatf("value %0d, expected %0d", got_val, want.value));
    if (got_code !== want.code)
      report_mismatch($sformatf("error code %0d, expected %0d", got_code, want.code));
  endtask
endclass

module rpn_expression_evaluator_tb;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 6;
  localparam int STALL_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 60;
  localparam int PHASE_CHARS  = 475;
  localparam int NUM_PHASES   = 4;

  localparam logic [CHAR_W-1:0] OP_CHARS [4] = '{CH_PLUS, CH_MINUS, CH_MUL, CH_DIV};
  localparam int IDLE_PCT  [NUM_PHASES] = '{0, 67, 0, 32};
  localparam int STALL_PCT [NUM_PHASES] = '{0, 0, 67, 32};

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  rpn_char_if   char_if ();
  rpn_result_if res_if ();

  rpn_expression_evaluator DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .char_i (char_if),
    .res_o  (res_if)
  );

  expr_scoreboard sb = new();

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int chars_fed      = 0;
  int quiet_cycles   = 0;

  always #CLK_HALF clk_i = ~clk_i;

  initial begin
    char_if.valid   = 1'b0;
    char_if.char_in = '0;
    res_if.ready    = 1'b0;
  end

  always @(negedge clk_i) begin
    res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready)
      sb.check_result(res_if.result_value, res_if.error_code);
  end

  // counts cycles with no beat on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (char_if.valid && char_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  function automatic void append_text(ref char_q_t q, input string s);
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
  endfunction

  function automatic string num_text();
    longint unsigned v;
    case ($urandom_range(9))
      0, 1, 2, 3: v = $urandom_range(0, 99);
      4, 5, 6:    v = $urandom_range(0, 65535);
      7, 8:       v = $urandom;
      default:    v = {$urandom, $urandom};
    endcase
    return $sformatf("%0d", v);
  endfunction

  function automatic void add_terminator(ref char_q_t q);
    if ($urandom_range(1)) begin
      q.push_back(CH_LF);
    end else begin
      q.push_back(CH_DOT);
      repeat ($urandom_range(0, 4)) q.push_back(CHAR_W'($urandom_range(0, 255)));
      q.push_back(CH_LF);
    end
  endfunction

  function automatic char_q_t gen_expression();
    char_q_t q;
    int      pick;
    int      depth;
    int      pushed;
    int      operands;
    pick = $urandom_range(99);
    if (pick < 70) begin
      depth    = 0;
      pushed   = 0;
      operands = $urandom_range(1, 6);
      while (pushed < operands || depth > 1) begin
        if (pushed < operands && (depth < 2 || $urandom_range(1) == 0)) begin
          append_text(q, num_text());
          depth++;
          pushed++;
          if ($urandom_range(4) != 0) q.push_back(CH_SPACE);
        end else begin
          q.push_back(OP_CHARS[$urandom_range(3)]);
          depth--;
          if ($urandom_range(3) == 0) q.push_back(CH_SPACE);
        end
      end
    end else if (pick < 85) begin
      // loose token soup: underflow, leftovers, stray symbols
      repeat ($urandom_range(1, 8)) begin
        case ($urandom_range(3))
          0:       append_text(q, num_text());
          1:       q.push_back(OP_CHARS[$urandom_range(3)]);
          2:       q.push_back(CHAR_W'($urandom_range(33, 126)));
          default: q.push_back(CH_SPACE);
        endcase
      end
    end else if (pick < 93) begin
      repeat ($urandom_range(1, 12)) q.push_back(CHAR_W'($urandom_range(0, 255)));
    end else begin
      case ($urandom_range(7))
        0:       append_text(q, "2147483648 0 1-/");
        1:       append_text(q, "0 7-2/");
        2:       append_text(q, "4294967295 1+");
        3:       append_text(q, "65536 65536*");
        4:       append_text(q, "7 0 2-/");
        5:       append_text(q, "1 0/ +");
        6:       append_text(q, "3#");
        default: append_text(q, "2147483647 1+ 0 1-*");
      endcase
    end
    add_terminator(q);
    return q;
  endfunction

  task automatic send_char(input logic [CHAR_W-1:0] c);
    char_if.valid   <= 1'b1;
    char_if.char_in <= c;
    @(posedge clk_i);
    while (!char_if.ready) @(posedge clk_i);
    if (sb.note_char(c)) chars_fed++;
    @(negedge clk_i);
    if ($urandom_range(99) < send_idle_pct) begin
      char_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
  endtask

  task automatic send_text(input char_q_t text);
    foreach (text[i]) send_char(text[i]);
  endtask

  // hold the sender until every ended expression has come back
  task automatic drain_results();
    char_if.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    char_q_t text;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // subtract order, divide by zero, underflow then skip, pending number, unknown char
    append_text(text, "7 3-\n9 0/\n+.x\n42\n6 4#\n");
    send_text(text);
    drain_results();

    for (int p = 0; p < NUM_PHASES; p++) begin
      send_idle_pct  = IDLE_PCT[p];
      recv_stall_pct = STALL_PCT[p];
      chars_fed      = 0;
      if (p == NUM_PHASES - 1) begin
        // push past the stack depth, then add the top two
        text.delete();
        repeat (STACK_DEPTH + 2) begin
          text.push_back(CHAR_W'(CH_0 + $urandom_range(0, 9)));
          text.push_back(CH_SPACE);
        end
        text.push_back(CH_PLUS);
        text.push_back(CH_LF);
        send_text(text);
      end
      while (chars_fed < PHASE_CHARS) send_text(gen_expression());
      drain_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.outstanding() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.outstanding()));
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
